[hw/rtl/cau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg: shared types and codes for the complex arithmetic unit
// Holds the request codes and the record that travels down the divider chain.
// ----------------------------------------------------------------------------
package cau_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4,
        OP_CMP = 3'd5,
        OP_RS6 = 3'd6,
        OP_RS7 = 3'd7
    } op_t;

    // Side information that follows a request through the chain.
    typedef struct packed {
        logic valid;
        logic dz;
        logic neg_re;
        logic neg_im;
    } tag_t;

endpackage

[hw/rtl/cau_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_cell: one restoring-division step for two quotients
// Shift in one numerator bit, try the subtract, hand the result on.
// ----------------------------------------------------------------------------
module cau_div_cell
    import cau_pkg::*;
#(
    parameter int NW = 96,
    parameter int DW = 66,
    parameter int QW = 48
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  tag_t          tag_in,
    input  logic [NW-1:0] nre_in,
    input  logic [NW-1:0] nim_in,
    input  logic [DW-1:0] rre_in,
    input  logic [DW-1:0] rim_in,
    input  logic [QW-1:0] qre_in,
    input  logic [QW-1:0] qim_in,
    input  logic [DW-1:0] den_in,
    input  logic [QW-1:0] pre_in,
    input  logic [QW-1:0] pim_in,
    input  logic [QW-1:0] hre_in,
    input  logic [QW-1:0] him_in,
    output tag_t          tag_out,
    output logic [NW-1:0] nre_out,
    output logic [NW-1:0] nim_out,
    output logic [DW-1:0] rre_out,
    output logic [DW-1:0] rim_out,
    output logic [QW-1:0] qre_out,
    output logic [QW-1:0] qim_out,
    output logic [DW-1:0] den_out,
    output logic [QW-1:0] pre_out,
    output logic [QW-1:0] pim_out,
    output logic [QW-1:0] hre_out,
    output logic [QW-1:0] him_out
);

    tag_t          tag_reg;
    logic [NW-1:0] nre_reg, nim_reg;
    logic [DW-1:0] rre_reg, rim_reg, den_reg;
    logic [QW-1:0] qre_reg, qim_reg, pre_reg, pim_reg, hre_reg, him_reg;
    logic [DW:0]   tre, tim, dre, dim;

    always_comb
    begin
        tre = {rre_in, nre_in[NW-1]};
        tim = {rim_in, nim_in[NW-1]};
        dre = tre - {1'b0, den_in};
        dim = tim - {1'b0, den_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nre_reg <= {nre_in[NW-2:0], 1'b0};
            nim_reg <= {nim_in[NW-2:0], 1'b0};
            rre_reg <= dre[DW] ? tre[DW-1:0] : dre[DW-1:0];
            rim_reg <= dim[DW] ? tim[DW-1:0] : dim[DW-1:0];
            qre_reg <= {qre_in[QW-2:0], ~dre[DW]};
            qim_reg <= {qim_in[QW-2:0], ~dim[DW]};
            den_reg <= den_in;
            pre_reg <= pre_in;
            pim_reg <= pim_in;
            hre_reg <= hre_in;
            him_reg <= him_in;
        end
    end

    assign tag_out = tag_reg;
    assign nre_out = nre_reg;
    assign nim_out = nim_reg;
    assign rre_out = rre_reg;
    assign rim_out = rim_reg;
    assign qre_out = qre_reg;
    assign qim_out = qim_reg;
    assign den_out = den_reg;
    assign pre_out = pre_reg;
    assign pim_out = pim_reg;
    assign hre_out = hre_reg;
    assign him_out = him_reg;

endmodule

[hw/rtl/complex_arithmetic_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex ALU in signed fixed point
// Add, subtract, multiply, divide, negate and compare on complex operands.
// ----------------------------------------------------------------------------
// Every request yields one result, in order. A new request is taken every
// cycle while the output is not stalled. The latency is the same for all
// operations: an operand register, a product stage, a sum stage, a row of
// 2*DATA_WIDTH+FRAC_BITS+1 divider cells and one output register. Each
// divider cell retires one quotient bit of both parts. Operands and
// results are Q16.16 at the default widths. Results saturate and raise the
// saturated flag; a zero divisor returns zero with div_by_zero set.
// A stall on the output freezes the whole pipeline, so in_stall follows it.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   req_type,
    input  logic signed [DATA_WIDTH-1:0] a_re,
    input  logic signed [DATA_WIDTH-1:0] a_im,
    input  logic signed [DATA_WIDTH-1:0] b_re,
    input  logic signed [DATA_WIDTH-1:0] b_im,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] res_re,
    output logic signed [DATA_WIDTH-1:0] res_im,
    output logic                         is_equal,
    output logic                         div_by_zero,
    output logic                         saturated
);

    localparam int W   = DATA_WIDTH;
    localparam int PW  = 2 * W + 1;          // sum of two products
    localparam int DW  = 2 * W + 2;          // remainder / denominator width
    localparam int NW  = PW + FRAC_BITS;     // shifted numerator magnitude
    localparam int QW  = W + 2;              // kept low quotient bits + sticky
    localparam int NC  = NW;                 // divider cells

    // Clip bounds of a W-bit signed result, widened to the sum width.
    localparam logic signed [PW-1:0] SAT_HI = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};

    // Whole pipe advances together; the output register is the only hold point.
    logic adv;
    assign adv      = ~(out_valid & out_stall);
    assign in_stall = ~adv;

    // ---- stage 1: register operands and op
    logic                s1_v_reg;
    op_t                 s1_op_reg;
    logic signed [W-1:0] s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;

    // ---- stage 2: products
    logic                s2_v_reg;
    op_t                 s2_op_reg;
    logic signed [2*W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;
    logic signed [W:0]   s2_sre_reg, s2_sim_reg;
    logic                s2_eq_reg;

    // ---- stage 3: sums
    logic                s3_v_reg;
    op_t                 s3_op_reg;
    logic signed [PW-1:0] s3_re_reg, s3_im_reg;
    logic [DW-1:0]       s3_den_reg;
    logic                s3_eq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg <= op_t'(req_type);
            s1_ar_reg <= a_re;
            s1_ai_reg <= a_im;
            s1_br_reg <= b_re;
            s1_bi_reg <= b_im;
            // Products, and the plain sums selected by op so add/sub/neg reuse the sum path.
            s2_op_reg <= s1_op_reg;
            p_rr_reg  <= s1_ar_reg * s1_br_reg;
            p_ii_reg  <= s1_ai_reg * s1_bi_reg;
            p_ri_reg  <= s1_ar_reg * s1_bi_reg;
            p_ir_reg  <= s1_ai_reg * s1_br_reg;
            p_bb_reg  <= s1_br_reg * s1_br_reg;
            p_cc_reg  <= s1_bi_reg * s1_bi_reg;
            s2_eq_reg <= (s1_ar_reg == s1_br_reg) && (s1_ai_reg == s1_bi_reg);
            case (s1_op_reg)
                OP_ADD:
                begin
                    s2_sre_reg <= {s1_ar_reg[W-1], s1_ar_reg} + {s1_br_reg[W-1], s1_br_reg};
                    s2_sim_reg <= {s1_ai_reg[W-1], s1_ai_reg} + {s1_bi_reg[W-1], s1_bi_reg};
                end
                OP_SUB:
                begin
                    s2_sre_reg <= {s1_ar_reg[W-1], s1_ar_reg} - {s1_br_reg[W-1], s1_br_reg};
                    s2_sim_reg <= {s1_ai_reg[W-1], s1_ai_reg} - {s1_bi_reg[W-1], s1_bi_reg};
                end
                default:
                begin
                    s2_sre_reg <= -{s1_ar_reg[W-1], s1_ar_reg};
                    s2_sim_reg <= -{s1_ai_reg[W-1], s1_ai_reg};
                end
            endcase
            // Sums of products, or the plain sums widened.
            s3_op_reg  <= s2_op_reg;
            s3_eq_reg  <= s2_eq_reg;
            s3_den_reg <= DW'({1'b0, p_bb_reg} + {1'b0, p_cc_reg});
            case (s2_op_reg)
                OP_MUL:
                begin
                    s3_re_reg <= {p_rr_reg[2*W-1], p_rr_reg} - {p_ii_reg[2*W-1], p_ii_reg};
                    s3_im_reg <= {p_ri_reg[2*W-1], p_ri_reg} + {p_ir_reg[2*W-1], p_ir_reg};
                end
                OP_DIV:
                begin
                    s3_re_reg <= {p_rr_reg[2*W-1], p_rr_reg} + {p_ii_reg[2*W-1], p_ii_reg};
                    s3_im_reg <= {p_ir_reg[2*W-1], p_ir_reg} - {p_ri_reg[2*W-1], p_ri_reg};
                end
                default:
                begin
                    s3_re_reg <= PW'(s2_sre_reg);
                    s3_im_reg <= PW'(s2_sim_reg);
                end
            endcase
        end
    end

    // ---- stage 4 prep: final non-divide result, divider entry
    // Clip a wide signed value to W bits.
    logic signed [PW-1:0] mre, mim;
    logic [W-1:0]         c_re, c_im;
    logic                 c_sat;
    logic [PW-1:0]        mag_re, mag_im;
    logic [QW-1:0]        pass_re, pass_im, pass_fl;
    logic                 dz;
    tag_t                 tag0;

    always_comb
    begin
        mre = (s3_op_reg == OP_MUL) ? (s3_re_reg >>> FRAC_BITS) : s3_re_reg;
        mim = (s3_op_reg == OP_MUL) ? (s3_im_reg >>> FRAC_BITS) : s3_im_reg;
        c_sat = 1'b0;
        if (mre > SAT_HI)
        begin
            c_re = {1'b0, {(W-1){1'b1}}};
            c_sat = 1'b1;
        end
        else if (mre < SAT_LO)
        begin
            c_re = {1'b1, {(W-1){1'b0}}};
            c_sat = 1'b1;
        end
        else
        begin
            c_re = mre[W-1:0];
        end
        if (mim > SAT_HI)
        begin
            c_im = {1'b0, {(W-1){1'b1}}};
            c_sat = 1'b1;
        end
        else if (mim < SAT_LO)
        begin
            c_im = {1'b1, {(W-1){1'b0}}};
            c_sat = 1'b1;
        end
        else
        begin
            c_im = mim[W-1:0];
        end
        mag_re = s3_re_reg[PW-1] ? -s3_re_reg : s3_re_reg;
        mag_im = s3_im_reg[PW-1] ? -s3_im_reg : s3_im_reg;
        dz = (s3_den_reg == '0);
        // Pass-through fields: low W bits are the result; pass_fl bits 0 to 3 hold eq, dz, sat, divide.
        pass_re = '0;
        pass_im = '0;
        pass_fl = '0;
        case (s3_op_reg)
            OP_ADD, OP_SUB, OP_MUL, OP_NEG:
            begin
                pass_re[W-1:0] = c_re;
                pass_im[W-1:0] = c_im;
                pass_fl[2]     = c_sat;
            end
            OP_CMP:
            begin
                pass_fl[0] = s3_eq_reg;
            end
            OP_DIV:
            begin
                pass_fl[1] = dz;
                pass_fl[3] = 1'b1;
            end
            default:
            begin
                pass_fl = '0;
            end
        endcase
        tag0.valid  = s3_v_reg;
        tag0.dz     = dz;
        tag0.neg_re = s3_re_reg[PW-1];
        tag0.neg_im = s3_im_reg[PW-1];
    end

    // ---- divider chain
    tag_t          c_tag [0:NC];
    logic [NW-1:0] c_nre [0:NC];
    logic [NW-1:0] c_nim [0:NC];
    logic [DW-1:0] c_rre [0:NC];
    logic [DW-1:0] c_rim [0:NC];
    logic [QW-1:0] c_qre [0:NC];
    logic [QW-1:0] c_qim [0:NC];
    logic [DW-1:0] c_den [0:NC];
    logic [QW-1:0] c_pre [0:NC];
    logic [QW-1:0] c_pim [0:NC];
    logic [QW-1:0] c_hre [0:NC];
    logic [QW-1:0] c_him [0:NC];

    assign c_tag[0] = tag0;
    assign c_nre[0] = {mag_re, {FRAC_BITS{1'b0}}};
    assign c_nim[0] = {mag_im, {FRAC_BITS{1'b0}}};
    assign c_rre[0] = '0;
    assign c_rim[0] = '0;
    assign c_qre[0] = '0;
    assign c_qim[0] = '0;
    assign c_den[0] = s3_den_reg;
    assign c_pre[0] = pass_re;
    assign c_pim[0] = pass_im;
    assign c_hre[0] = pass_fl;
    assign c_him[0] = '0;

    genvar g;
    generate
        for (g = 0; g < NC; g++)
        begin : g_cell
            cau_div_cell #(.NW(NW), .DW(DW), .QW(QW)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (adv),
                .tag_in  (c_tag[g]),
                .nre_in  (c_nre[g]),
                .nim_in  (c_nim[g]),
                .rre_in  (c_rre[g]),
                .rim_in  (c_rim[g]),
                .qre_in  (c_qre[g]),
                .qim_in  (c_qim[g]),
                .den_in  (c_den[g]),
                .pre_in  (c_pre[g]),
                .pim_in  (c_pim[g]),
                .hre_in  (c_hre[g]),
                .him_in  ({c_him[g][QW-1:2], c_him[g][1] | c_qim[g][QW-1],
                           c_him[g][0] | c_qre[g][QW-1]}),
                .tag_out (c_tag[g+1]),
                .nre_out (c_nre[g+1]),
                .nim_out (c_nim[g+1]),
                .rre_out (c_rre[g+1]),
                .rim_out (c_rim[g+1]),
                .qre_out (c_qre[g+1]),
                .qim_out (c_qim[g+1]),
                .den_out (c_den[g+1]),
                .pre_out (c_pre[g+1]),
                .pim_out (c_pim[g+1]),
                .hre_out (c_hre[g+1]),
                .him_out (c_him[g+1])
            );
        end
    endgenerate

    // ---- output stage: sign, clip, register
    logic          fin_v;
    logic [QW-1:0] qr, qi;
    logic          ovr, ovi;
    logic [W:0]    sre, sim;
    logic [W-1:0]  o_re, o_im;
    logic          o_eq, o_dz, o_sat;

    always_comb
    begin
        fin_v = c_tag[NC].valid;
        qr    = c_qre[NC];
        qi    = c_qim[NC];
        // Quotient bits that shifted out of the kept window are sticky in him.
        ovr   = c_him[NC][0] | qr[QW-1] | qr[QW-2];
        ovi   = c_him[NC][1] | qi[QW-1] | qi[QW-2];
        o_eq  = c_hre[NC][0];
        o_dz  = c_hre[NC][1];
        o_sat = c_hre[NC][2];
        o_re  = c_pre[NC][W-1:0];
        o_im  = c_pim[NC][W-1:0];
        sre   = '0;
        sim   = '0;
        if (c_hre[NC][3] && !o_dz)
        begin
            o_sat = 1'b0;
            sre = c_tag[NC].neg_re ? -qr[W:0] : qr[W:0];
            sim = c_tag[NC].neg_im ? -qi[W:0] : qi[W:0];
            if (ovr || (!c_tag[NC].neg_re && qr[W-1]) || (c_tag[NC].neg_re && qr[W]))
            begin
                o_re = c_tag[NC].neg_re ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                o_sat = 1'b1;
            end
            else if (c_tag[NC].neg_re && qr[W-1] && (qr[W-2:0] != '0))
            begin
                o_re = {1'b1, {(W-1){1'b0}}};
                o_sat = 1'b1;
            end
            else
            begin
                o_re = sre[W-1:0];
            end
            if (ovi || (!c_tag[NC].neg_im && qi[W-1]) || (c_tag[NC].neg_im && qi[W]))
            begin
                o_im = c_tag[NC].neg_im ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                o_sat = 1'b1;
            end
            else if (c_tag[NC].neg_im && qi[W-1] && (qi[W-2:0] != '0))
            begin
                o_im = {1'b1, {(W-1){1'b0}}};
                o_sat = 1'b1;
            end
            else
            begin
                o_im = sim[W-1:0];
            end
        end
    end

    logic         out_valid_reg;
    logic [W-1:0] res_re_reg, res_im_reg;
    logic         is_equal_reg, div_by_zero_reg, saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= fin_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_re_reg      <= o_re;
            res_im_reg      <= o_im;
            is_equal_reg    <= o_eq;
            div_by_zero_reg <= o_dz;
            saturated_reg   <= o_sat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign res_re      = res_re_reg;
    assign res_im      = res_im_reg;
    assign is_equal    = is_equal_reg;
    assign div_by_zero = div_by_zero_reg;
    assign saturated   = saturated_reg;

endmodule

[sim/cau_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_checker: result predictor and scoreboard for the complex ALU
// Watches both channels, computes the expected result of every accepted
// request and compares it with the results leaving the block, in order.
// ----------------------------------------------------------------------------
module cau_checker
    import cau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] a_re,
    input  logic signed [31:0] a_im,
    input  logic signed [31:0] b_re,
    input  logic signed [31:0] b_im,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] res_re,
    input  logic signed [31:0] res_im,
    input  logic               is_equal,
    input  logic               div_by_zero,
    input  logic               saturated,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count
);

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               eq;
        logic               dz;
        logic               sat;
    } alu_result_t;

    alu_result_t expected_results[$];

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] x,
                                                   inout logic sat);
        if (x > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (x < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    // Truncating quotient of (num << 16) / den, den positive.
    function automatic logic signed [127:0] fx_quot(input logic signed [127:0] num,
                                                    input logic signed [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = num[127] ? -num : num;
        q = (mag << 16) / den;
        return num[127] ? -$signed(q) : $signed(q);
    endfunction

    function automatic alu_result_t predict_alu(input logic [2:0] op,
        input logic signed [31:0] ar, input logic signed [31:0] ai,
        input logic signed [31:0] br, input logic signed [31:0] bi);
        alu_result_t r;
        logic signed [127:0] xr, xi, yr, yi, den;
        logic sat;
        r = '0;
        sat = 1'b0;
        xr = ar; xi = ai; yr = br; yi = bi;
        case (op_t'(op))
            OP_ADD:
            begin
                r.re = clamp32(xr + yr, sat);
                r.im = clamp32(xi + yi, sat);
            end
            OP_SUB:
            begin
                r.re = clamp32(xr - yr, sat);
                r.im = clamp32(xi - yi, sat);
            end
            OP_MUL:
            begin
                r.re = clamp32((xr * yr - xi * yi) >>> 16, sat);
                r.im = clamp32((xr * yi + xi * yr) >>> 16, sat);
            end
            OP_DIV:
            begin
                den = yr * yr + yi * yi;
                if (den == 0)
                    r.dz = 1'b1;
                else
                begin
                    r.re = clamp32(fx_quot(xr * yr + xi * yi, den), sat);
                    r.im = clamp32(fx_quot(xi * yr - xr * yi, den), sat);
                end
            end
            OP_NEG:
            begin
                r.re = clamp32(-xr, sat);
                r.im = clamp32(-xi, sat);
            end
            OP_CMP: r.eq = (ar == br) && (ai == bi);
            default: ;
        endcase
        r.sat = sat;
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        alu_result_t e;
        if (!rst_n)
        begin
            fail_count   <= 0;
            result_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(predict_alu(req_type, a_re, a_im, b_re, b_im));
            if (out_valid && !out_stall)
            begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result re=%h im=%h", $time, res_re, res_im);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (e != {res_re, res_im, is_equal, div_by_zero, saturated})
                    begin
                        $display("%0t: mismatch expected re=%h im=%h eq=%b dz=%b sat=%b",
                                 $time, e.re, e.im, e.eq, e.dz, e.sat);
                        $display("%0t:          actual   re=%h im=%h eq=%b dz=%b sat=%b",
                                 $time, res_re, res_im, is_equal, div_by_zero, saturated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the complex arithmetic unit
// Drives directed corner requests and then random ones under three idling
// mixes plus one long output hold-off; a checker beside the block scores it.
// ----------------------------------------------------------------------------
module tb_top
    import cau_pkg::*;
();

    localparam int LATENCY = 2 * 32 + 16 + 5;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         req_type;
    logic signed [31:0] a_re, a_im, b_re, b_im;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] res_re, res_im;
    logic               is_equal, div_by_zero, saturated;
    int                 fail_count, pending, result_count;

    // Idle percentages, changed per phase.
    int send_idle_pct = 35;
    int recv_idle_pct = 53;
    // Set to hold the receiver off for a long stretch.
    bit hold_off = 1'b0;

    complex_arithmetic_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .out_valid(out_valid), .out_stall(out_stall),
        .res_re(res_re), .res_im(res_im),
        .is_equal(is_equal), .div_by_zero(div_by_zero), .saturated(saturated)
    );

    cau_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .out_valid(out_valid), .out_stall(out_stall),
        .res_re(res_re), .res_im(res_im),
        .is_equal(is_equal), .div_by_zero(div_by_zero), .saturated(saturated),
        .fail_count(fail_count), .pending(pending), .result_count(result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stall, or solid stall during a hold-off.
    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

    // Pick an operand: often a corner value or a small one, else random.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'h00010000;
            4: return 32'hffff0000;
            5: return $urandom_range(0, 32'h3ffff) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic send_request(input logic [2:0] op, input logic [31:0] ar,
                                input logic [31:0] ai, input logic [31:0] br,
                                input logic [31:0] bi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        logic [2:0]  op;
        logic [31:0] ar, ai, br, bi;
        repeat (count)
        begin
            op = 3'($urandom_range(7));
            ar = pick_operand(); ai = pick_operand();
            br = pick_operand(); bi = pick_operand();
            // Make compares and zero divisors hit often enough.
            if (op == OP_CMP && $urandom_range(1))
            begin
                br = ar;
                bi = ($urandom_range(3) == 0) ? ai ^ (32'd1 << $urandom_range(31)) : ai;
            end
            if (op == OP_DIV && $urandom_range(7) == 0)
            begin
                br = '0;
                bi = '0;
            end
            send_request(op, ar, ai, br, bi);
        end
    endtask

    initial
    begin
        int hold_cycles;
        in_valid = 1'b0;
        req_type = '0;
        a_re = '0; a_im = '0; b_re = '0; b_im = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, each operation, zero divisor, compare, unused codes.
        send_request(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff);
        send_request(OP_ADD, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0);
        send_request(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff);
        send_request(OP_SUB, 32'h00010000, 32'h0, 32'h00020000, 32'h0);
        send_request(OP_MUL, 32'h00020000, 32'h00030000, 32'h00040000, 32'hffff0000);
        send_request(OP_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_request(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_request(OP_MUL, 32'hffffffff, 32'h0, 32'h1, 32'h0);
        send_request(OP_DIV, 32'h00010000, 32'h0, 32'h00020000, 32'h0);
        send_request(OP_DIV, 32'hfffe0000, 32'h00010000, 32'h00010000, 32'h00010000);
        send_request(OP_DIV, 32'h12345678, 32'h9abcdef0, 32'h0, 32'h0);
        send_request(OP_DIV, 32'h7fffffff, 32'h80000000, 32'h1, 32'h0);
        send_request(OP_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_request(OP_NEG, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0);
        send_request(OP_NEG, 32'h00010000, 32'h0, 32'hffffffff, 32'hffffffff);
        send_request(OP_CMP, 32'h5, 32'h6, 32'h5, 32'h6);
        send_request(OP_CMP, 32'h5, 32'h6, 32'h5, 32'h7);
        send_request(OP_CMP, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_request(OP_RS6, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_request(OP_RS7, 32'h1, 32'h2, 32'h3, 32'h4);

        random_phase(160);
        send_idle_pct = 53;
        recv_idle_pct = 35;
        random_phase(160);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Long output hold-off while requests keep arriving: fill the pipe.
        fork
            begin
                hold_off = 1'b1;
                hold_cycles = 0;
                while (hold_cycles < 3 * LATENCY)
                begin
                    @(posedge clk);
                    hold_cycles++;
                end
                hold_off = 1'b0;
            end
            random_phase(180);
        join
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);

        $display("Ran %0d results: all six operations, both unused codes, saturation,",
                 result_count);
        $display("zero divisors and compares, under three idle mixes and a full-pipe stall.");
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
